// ----- src/sspg_pkg.sv -----
// Package with the constants and types of the stepper step pulse generator.
package sspg_pkg;

    localparam int STEP_BITS_DEF = 24;
    localparam int COUNT_W       = 24;
    localparam int RPM_W         = 16;
    localparam int PROD_W        = COUNT_W + RPM_W;
    localparam int QUOT_W        = 26;
    localparam int HALF_W        = 25;
    localparam int CNT_W         = 5;
    localparam int MODE_W        = 2;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [QUOT_W-1:0] US_PER_MINUTE = QUOT_W'(60000000);
    localparam logic [CNT_W-1:0]  DIV_FIRST     = CNT_W'(QUOT_W - 1);

    localparam logic REG_MODE = 1'b0;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

// ----- src/stepper_step_pulse_generator.sv -----
// Top level of the stepper step pulse generator with its period divider and sequencer.
//
//  channel  direction  handshake          payload
//  s_       input      s_valid / s_ready  s_opcode, s_step_count, s_speed_rpm
//  m_       output     m_valid / m_ready  step, direction, mode pins, busy, done, refused
//  apb      config     psel / penable     microstep_mode at byte address 0
//
// A tick word or a refused or zero-length start is answered straight from the idle state.
// An accepted start runs one multiply, 26 restoring divide steps and one commit, in that order.
// A zero product or one above the dividend skips the divide steps and goes straight to the commit.
// The divide loop produces one quotient bit per cycle, and the commit waits for a free output register.
// Reset is synchronous and active low and clears all pulse state, but not the output payload registers.
// A new word is taken only while the sequencer idles and the output register is free.
module stepper_step_pulse_generator #(
    parameter int STEP_BITS = sspg_pkg::STEP_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [sspg_pkg::COUNT_W-1:0] s_step_count,
    input  logic [sspg_pkg::RPM_W-1:0]    s_speed_rpm,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_step_level,
    output logic                          m_direction_level,
    output logic                          m_mode_pin_one,
    output logic                          m_mode_pin_two,
    output logic                          m_busy_res,
    output logic                          m_move_done,
    output logic                          m_start_refused,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sspg_pkg::ADDR_W-1:0]   paddr,
    input  logic [sspg_pkg::DATA_W-1:0]   pwdata,
    output logic [sspg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import sspg_pkg::*;

    localparam int WIDE_W = (STEP_BITS > COUNT_W) ? STEP_BITS : COUNT_W;

    state_t                state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg;
    logic [STEP_BITS-1:0]  steps_left_reg, steps_left_next;
    logic [HALF_W-1:0]     half_reg, half_next;
    logic [HALF_W-1:0]     tick_reg, tick_next;
    logic                  pulse_reg, pulse_next;
    logic                  dir_reg, dir_next;
    logic                  run_reg, run_next;
    logic [COUNT_W-1:0]    mag_reg, mag_next;
    logic [RPM_W-1:0]      rpm_reg, rpm_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [QUOT_W-1:0]     rem_reg, rem_next;
    logic [QUOT_W-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  o_step_reg, o_dir_reg, o_busy_reg, o_done_reg, o_refused_reg;
    logic [MODE_W-1:0]     o_mode_reg;

    logic                  out_load, done_flag, refused_flag;
    logic                  accept;
    logic                  neg;
    logic [COUNT_W-1:0]    raw;
    logic                  div_skip;
    logic [QUOT_W:0]       rem_shift;
    logic [QUOT_W:0]       divisor;
    logic [HALF_W-1:0]     tick_inc;
    logic [HALF_W-1:0]     half_calc;
    logic [WIDE_W-1:0]     mag_wide, mask_wide, sat_wide;
    logic [STEP_BITS-1:0]  steps_dec;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign raw     = s_step_count;
    assign neg     = raw[COUNT_W-1];

    assign div_skip  = (prod_reg == '0) || (prod_reg > PROD_W'(US_PER_MINUTE));
    assign divisor   = {1'b0, prod_reg[QUOT_W-1:0]};
    assign rem_shift = {rem_reg, US_PER_MINUTE[cnt_reg]};
    assign tick_inc  = tick_reg + 1'b1;
    assign steps_dec = steps_left_reg - 1'b1;
    assign half_calc = (q_reg[QUOT_W-1:1] == '0) ? HALF_W'(1) : q_reg[QUOT_W-1:1];
    assign mag_wide  = WIDE_W'(mag_reg);
    assign mask_wide = WIDE_W'({STEP_BITS{1'b1}});
    assign sat_wide  = (mag_wide > mask_wide) ? mask_wide : mag_wide;

    always_comb begin
        state_next      = state_reg;
        steps_left_next = steps_left_reg;
        half_next       = half_reg;
        tick_next       = tick_reg;
        pulse_next      = pulse_reg;
        dir_next        = dir_reg;
        run_next        = run_reg;
        mag_next        = mag_reg;
        rpm_next        = rpm_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;
        out_load        = 1'b0;
        done_flag       = 1'b0;
        refused_flag    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_START) begin
                        if (run_reg) begin
                            refused_flag = 1'b1;
                            out_load     = 1'b1;
                        end else if (raw == '0) begin
                            dir_next  = 1'b1;
                            done_flag = 1'b1;
                            out_load  = 1'b1;
                        end else begin
                            mag_next   = neg ? (~raw + 1'b1) : raw;
                            rpm_next   = s_speed_rpm;
                            dir_next   = !neg;
                            state_next = ST_MUL;
                        end
                    end else begin
                        out_load = 1'b1;
                        if (run_reg) begin
                            tick_next = tick_inc;
                            if (tick_inc >= half_reg) begin
                                tick_next = '0;
                                if (pulse_reg) begin
                                    pulse_next = 1'b0;
                                end else begin
                                    steps_left_next = steps_dec;
                                    if (steps_dec == '0) begin
                                        run_next  = 1'b0;
                                        done_flag = 1'b1;
                                    end else begin
                                        pulse_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            ST_MUL: begin
                prod_next  = mag_reg * rpm_reg;
                rem_next   = '0;
                q_next     = '0;
                cnt_next   = DIV_FIRST;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if ((cnt_reg == DIV_FIRST) && div_skip) begin
                    q_next     = '0;
                    state_next = ST_DONE;
                end else begin
                    if (rem_shift >= divisor) begin
                        rem_next = QUOT_W'(rem_shift - divisor);
                        q_next   = {q_reg[QUOT_W-2:0], 1'b1};
                    end else begin
                        rem_next = rem_shift[QUOT_W-1:0];
                        q_next   = {q_reg[QUOT_W-2:0], 1'b0};
                    end
                    if (cnt_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    half_next       = half_calc;
                    steps_left_next = sat_wide[STEP_BITS-1:0];
                    tick_next       = '0;
                    pulse_next      = 1'b1;
                    run_next        = 1'b1;
                    out_load        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= '0;
            steps_left_reg <= '0;
            half_reg       <= '0;
            tick_reg       <= '0;
            pulse_reg      <= 1'b0;
            dir_reg        <= 1'b0;
            run_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            steps_left_reg <= steps_left_next;
            half_reg       <= half_next;
            tick_reg       <= tick_next;
            pulse_reg      <= pulse_next;
            dir_reg        <= dir_next;
            run_reg        <= run_next;
            m_valid_reg    <= m_valid_next;
            if (psel && penable && pwrite && (paddr[2] == REG_MODE)) begin
                mode_reg <= pwdata[MODE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        rpm_reg  <= rpm_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        if (out_load) begin
            o_step_reg    <= pulse_next;
            o_dir_reg     <= dir_next;
            o_busy_reg    <= run_next;
            o_done_reg    <= done_flag;
            o_refused_reg <= refused_flag;
            o_mode_reg    <= mode_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_step_level      = o_step_reg;
    assign m_direction_level = o_dir_reg;
    assign m_mode_pin_one    = o_mode_reg[0];
    assign m_mode_pin_two    = o_mode_reg[1];
    assign m_busy_res        = o_busy_reg;
    assign m_move_done       = o_done_reg;
    assign m_start_refused   = o_refused_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? DATA_W'(mode_reg) : '0;

endmodule
